FILE: rtl/register_datagram_engine_core_assert.svh
// ----------------------------------------------------------------------------
// Register datagram engine assertion macros
// Shared property forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef REGISTER_DATAGRAM_ENGINE_CORE_ASSERT_SVH
`define REGISTER_DATAGRAM_ENGINE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RDE_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("register datagram engine: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RDE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("register datagram engine: next-cycle check failed");

`endif

FILE: rtl/rde_pkg.sv
// ----------------------------------------------------------------------------
// Register datagram engine package
// Shared constants, command and status types, and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'h05;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] REG_MASK   = 8'h7F;
  localparam logic [7:0] WRITE_FLAG = 8'h80;

  localparam int FRAME_BYTES        = 8;
  localparam int READ_FRAME_BYTES   = 4;
  localparam int REPLY_BUFFER_BYTES = 32;
  localparam int QUEUE_DEPTH        = 2;

  localparam int IDX_W  = $clog2(FRAME_BYTES);
  localparam int SEEN_W = $clog2(REPLY_BUFFER_BYTES + 1);
  localparam int ECHO_W = $clog2(FRAME_BYTES + 1);
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Input action codes.
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_RX    = 2'd2;
  localparam logic [1:0] ACT_CLOSE = 2'd3;

  // Result kind codes.
  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_OK      = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  typedef enum logic [1:0] {
    CMD_READ,
    CMD_WRITE,
    CMD_RX,
    CMD_CLOSE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  addr;
    logic [7:0]  reg_byte;
    logic [31:0] value;
    logic [7:0]  rx;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic             empty;
  } fifo_status_t;

  typedef struct packed {
    logic idle;
    logic pop;
    logic emit;
    logic emit_last;
  } bk_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEND,
    BK_CHECK
  } bk_state_t;

  // CRC-8, polynomial 0x07, one byte taken LSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in;
    for (int b = 0; b < 8; b++) begin
      if (c[7] ^ data[b]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/rde_front.sv
// ----------------------------------------------------------------------------
// Register datagram engine front end
// Accepts input beats, classifies the action and holds one command for the queue.
// ----------------------------------------------------------------------------
module rde_front import rde_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   action,
  input  logic [7:0]   node_address,
  input  logic [6:0]   register_index,
  input  logic [31:0]  write_value,
  input  logic [7:0]   rx_byte,
  input  fifo_status_t fifo_stat,
  output logic         push,
  output cmd_t         cmd
);

  logic hold_valid;
  cmd_t cmd_q;
  cmd_t cmd_next;
  logic accept;

  assign in_stall = hold_valid && fifo_stat.full;
  assign push     = hold_valid && !fifo_stat.full;
  assign accept   = in_valid && !in_stall;
  assign cmd      = cmd_q;

  always_comb begin
    cmd_next.addr     = node_address;
    cmd_next.reg_byte = {1'b0, register_index};
    cmd_next.value    = write_value;
    cmd_next.rx       = rx_byte;
    cmd_next.op       = CMD_CLOSE;
    unique case (action)
      ACT_READ: begin
        cmd_next.op = CMD_READ;
      end
      ACT_WRITE: begin
        cmd_next.op       = CMD_WRITE;
        cmd_next.reg_byte = {1'b0, register_index} | WRITE_FLAG;
      end
      ACT_RX: begin
        cmd_next.op = CMD_RX;
      end
      ACT_CLOSE: begin
        cmd_next.op = CMD_CLOSE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_next;
    end
  end

endmodule

FILE: rtl/rde_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Register datagram engine command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rde_cmd_fifo import rde_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  cmd_t         push_cmd,
  input  logic         pop,
  output cmd_t         head,
  output fifo_status_t stat
);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.count = count;
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: rtl/rde_back.sv
// ----------------------------------------------------------------------------
// Register datagram engine back end
// Sends request datagrams, filters echo and reply bytes, and reports results.
// ----------------------------------------------------------------------------
module rde_back import rde_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  cmd_t        head,
  output bk_status_t  stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic        last,
  output logic [31:0] reply_value
);

  bk_state_t         state;
  bk_state_t         state_next;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_next;
  logic [7:0]        crc;
  logic [7:0]        crc_next;
  logic              is_write;
  logic              is_write_next;
  logic [7:0]        f_addr;
  logic [7:0]        f_addr_next;
  logic [7:0]        f_reg;
  logic [7:0]        f_reg_next;
  logic [31:0]       f_value;
  logic [31:0]       f_value_next;
  logic [7:0]        window      [FRAME_BYTES];
  logic [7:0]        window_next [FRAME_BYTES];
  logic [SEEN_W-1:0] bytes_seen;
  logic [SEEN_W-1:0] bytes_seen_next;
  logic [ECHO_W-1:0] echo_left;
  logic [ECHO_W-1:0] echo_left_next;
  logic              awaiting;
  logic              awaiting_next;
  logic [6:0]        exp_reg;
  logic [6:0]        exp_reg_next;

  logic              can_emit;
  logic              pop;
  logic              emit;
  logic [1:0]        emit_kind;
  logic [7:0]        emit_byte;
  logic              emit_last;
  logic [31:0]       emit_value;

  logic              rx_take;
  logic              candidate;
  logic [SEEN_W-1:0] seen_inc;
  logic [7:0]        send_data;
  logic              send_is_crc;
  logic [7:0]        send_byte;
  logic [7:0]        check_crc;
  logic              check_done;

  assign can_emit = !out_valid || !out_stall;
  assign pop      = (state == BK_IDLE) && head_valid && can_emit;

  assign seen_inc = bytes_seen + 1'b1;
  assign rx_take  = (echo_left == '0) && awaiting &&
                    (bytes_seen < SEEN_W'(REPLY_BUFFER_BYTES));
  // The shifted window starts at the current second byte; only such windows
  // with the right sync and register go on to the CRC check.
  assign candidate = (seen_inc >= SEEN_W'(FRAME_BYTES)) && (window[1] == SYNC_BYTE) &&
                     ((window[3] & REG_MASK) == {1'b0, exp_reg});

  always_comb begin
    case (idx)
      3'd0:    send_data = SYNC_BYTE;
      3'd1:    send_data = f_addr;
      3'd2:    send_data = f_reg;
      3'd3:    send_data = f_value[31:24];
      3'd4:    send_data = f_value[23:16];
      3'd5:    send_data = f_value[15:8];
      3'd6:    send_data = f_value[7:0];
      default: send_data = crc;
    endcase
  end

  assign send_is_crc = is_write ? (idx == IDX_W'(FRAME_BYTES - 1))
                                : (idx == IDX_W'(READ_FRAME_BYTES - 1));
  assign send_byte   = send_is_crc ? crc : send_data;
  assign check_crc   = crc8_byte(crc, window[idx]);
  assign check_done  = (idx == IDX_W'(FRAME_BYTES - 2));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (pop) begin
          unique case (head.op) inside
            CMD_READ, CMD_WRITE: state_next = BK_SEND;
            CMD_RX: begin
              if (rx_take && candidate) begin
                state_next = BK_CHECK;
              end
            end
            CMD_CLOSE: state_next = BK_IDLE;
          endcase
        end
      end
      BK_SEND: begin
        if (can_emit && send_is_crc) begin
          state_next = BK_IDLE;
        end
      end
      BK_CHECK: begin
        if (check_done && can_emit) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Datapath and result beats.
  always_comb begin
    idx_next        = idx;
    crc_next        = crc;
    is_write_next   = is_write;
    f_addr_next     = f_addr;
    f_reg_next      = f_reg;
    f_value_next    = f_value;
    bytes_seen_next = bytes_seen;
    echo_left_next  = echo_left;
    awaiting_next   = awaiting;
    exp_reg_next    = exp_reg;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      window_next[i] = window[i];
    end
    emit       = 1'b0;
    emit_kind  = KIND_TX;
    emit_byte  = '0;
    emit_last  = 1'b0;
    emit_value = '0;

    unique case (state)
      BK_IDLE: begin
        if (pop) begin
          unique case (head.op)
            CMD_READ: begin
              is_write_next   = 1'b0;
              f_addr_next     = head.addr;
              f_reg_next      = head.reg_byte;
              idx_next        = '0;
              crc_next        = '0;
              bytes_seen_next = '0;
              echo_left_next  = ECHO_W'(READ_FRAME_BYTES);
              awaiting_next   = 1'b1;
              exp_reg_next    = head.reg_byte[6:0];
              for (int i = 0; i < FRAME_BYTES; i++) begin
                window_next[i] = '0;
              end
            end
            CMD_WRITE: begin
              is_write_next  = 1'b1;
              f_addr_next    = head.addr;
              f_reg_next     = head.reg_byte;
              f_value_next   = head.value;
              idx_next       = '0;
              crc_next       = '0;
              echo_left_next = ECHO_W'(FRAME_BYTES);
              awaiting_next  = 1'b0;
            end
            CMD_RX: begin
              if (echo_left != '0) begin
                echo_left_next = echo_left - 1'b1;
              end else if (rx_take) begin
                for (int i = 0; i < FRAME_BYTES - 1; i++) begin
                  window_next[i] = window[i + 1];
                end
                window_next[FRAME_BYTES - 1] = head.rx;
                bytes_seen_next = seen_inc;
                idx_next        = '0;
                crc_next        = '0;
              end
            end
            CMD_CLOSE: begin
              echo_left_next = '0;
              if (awaiting) begin
                awaiting_next = 1'b0;
                emit          = 1'b1;
                emit_kind     = (bytes_seen < SEEN_W'(FRAME_BYTES)) ? KIND_TIMEOUT
                                                                     : KIND_INVALID;
              end
            end
          endcase
        end
      end
      BK_SEND: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_kind = KIND_TX;
          emit_byte = send_byte;
          emit_last = send_is_crc;
          crc_next  = crc8_byte(crc, send_byte);
          idx_next  = idx + 1'b1;
        end
      end
      BK_CHECK: begin
        if (!check_done) begin
          crc_next = check_crc;
          idx_next = idx + 1'b1;
        end else if (can_emit && (check_crc == window[FRAME_BYTES - 1])) begin
          awaiting_next = 1'b0;
          emit          = 1'b1;
          emit_kind     = KIND_OK;
          emit_value    = {window[3], window[4], window[5], window[6]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      bytes_seen <= '0;
      echo_left  <= '0;
      awaiting   <= 1'b0;
      exp_reg    <= '0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        window[i] <= '0;
      end
    end else begin
      state      <= state_next;
      bytes_seen <= bytes_seen_next;
      echo_left  <= echo_left_next;
      awaiting   <= awaiting_next;
      exp_reg    <= exp_reg_next;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        window[i] <= window_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    crc      <= crc_next;
    is_write <= is_write_next;
    f_addr   <= f_addr_next;
    f_reg    <= f_reg_next;
    f_value  <= f_value_next;
  end

  // Output register: a finished beat waits here, and the back end holds
  // until it leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind        <= emit_kind;
      tx_byte     <= emit_byte;
      last        <= emit_last;
      reply_value <= emit_value;
    end
  end

  assign stat.idle      = (state == BK_IDLE);
  assign stat.pop       = pop;
  assign stat.emit      = emit;
  assign stat.emit_last = emit_last;

endmodule

FILE: rtl/register_datagram_engine_core.sv
// ----------------------------------------------------------------------------
// Register datagram engine core
// Builds single-wire register bus request datagrams and decodes read replies.
// ----------------------------------------------------------------------------
// Input beats pass a one-entry front register and a two-entry command queue
// before the back end carries them out, so the input side keeps taking beats
// while a datagram is still going out. A read request produces four transmit
// beats and a write request eight, one per cycle while the output is free; the
// CRC-8 is folded in byte by byte as the datagram is sent. When a received
// byte's window has the right sync and register, the back end walks the seven
// frame bytes through the CRC, one byte a cycle. With the back end idle and the
// output free, the first result of an accepted beat passes the front register,
// the queue and the output register; a request also passes the send state.
`include "register_datagram_engine_core_assert.svh"

module register_datagram_engine_core import rde_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  node_address,
  input  logic [6:0]  register_index,
  input  logic [31:0] write_value,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic        last,
  output logic [31:0] reply_value
);

  fifo_status_t fifo_stat;
  bk_status_t   bk_stat;
  logic         push;
  cmd_t         front_cmd;
  cmd_t         head;

  rde_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .node_address   (node_address),
    .register_index (register_index),
    .write_value    (write_value),
    .rx_byte        (rx_byte),
    .fifo_stat      (fifo_stat),
    .push           (push),
    .cmd            (front_cmd)
  );

  rde_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (bk_stat.pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  rde_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (!fifo_stat.empty),
    .head        (head),
    .stat        (bk_stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .tx_byte     (tx_byte),
    .last        (last),
    .reply_value (reply_value)
  );

  // An accepted beat is either handed to the queue or held in the front stage.
  `RDE_ASSERT_NEXT(a_accept_kept, in_valid && !in_stall, push || in_stall)
  // The final byte of a datagram returns the back end to idle.
  `RDE_ASSERT_NEXT(a_last_to_idle, bk_stat.emit && bk_stat.emit_last, bk_stat.idle)
  // The back end never takes a command from an empty queue.
  `RDE_ASSERT_IMPLIES(a_no_pop_empty, fifo_stat.empty, !bk_stat.pop)
  // Queue occupancy stays within its depth.
  `RDE_ASSERT_IMPLIES(a_queue_bound, 1'b1, fifo_stat.count <= CNT_W'(QUEUE_DEPTH))

endmodule
